// ----- rtl/core/rhi_pkg.sv -----
// ----------------------------------------------------------------------------
// rhi_pkg
// Shared widths and types for the running h-index block.
// ----------------------------------------------------------------------------
package rhi_pkg;

   // fixed field widths of the item channels
   localparam int PAGE_WIDTH = 16;
   localparam int H_WIDTH    = 16;

   // width of one histogram entry
   localparam int HIST_WIDTH = 32;

   typedef logic [HIST_WIDTH-1:0] hist_type;

   // sequencing of the block: histogram clear after reset, then normal running
   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } rhi_state_type;

endpackage

// ----- rtl/core/rhi_channels.sv -----
// ----------------------------------------------------------------------------
// rhi_channels
// Valid/ready channels for page count items in and h-index items out.
// ----------------------------------------------------------------------------
interface rhi_req_if import rhi_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PAGE_WIDTH-1:0] page_count;

   modport source (output valid, output page_count, input ready);
   modport sink   (input valid, input page_count, output ready);
endinterface

interface rhi_rsp_if import rhi_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [H_WIDTH-1:0] h_value;

   modport source (output valid, output h_value, input ready);
   modport sink   (input valid, input h_value, output ready);
endinterface

// ----- rtl/core/rhi_ram.sv -----
// ----------------------------------------------------------------------------
// rhi_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (old data on a same-address read and write).
// ----------------------------------------------------------------------------
module rhi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- rtl/core/running_h_index.sv -----
// ----------------------------------------------------------------------------
// running_h_index
// Online h-index of a stream of page counts, built around a histogram memory.
//
//   channel   dir  fields            meaning
//   req_chan  in   page_count[15:0]  one value, clamped to 2^VALUE_BITS-1
//   rsp_chan  out  h_value[15:0]     running h-index after that value
//
// After reset the histogram is cleared one entry a cycle, all 2^VALUE_BITS
// entries (65536 at the default), with req_chan.ready low.
// No item is taken while one is in stage b; the histogram's single read port
// serves two reads per item (the value's entry, then the entry at h+1).
// An accepted item passes stage b, then stage c, which pushes its result.
// Results wait in a two-entry buffer; input is held off while an item sits in
// the first stage or while that buffer plus the item in the last stage fill it.
// ----------------------------------------------------------------------------
module running_h_index import rhi_pkg::*; #(
   parameter int VALUE_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   rhi_req_if.sink   req_chan,
   rhi_rsp_if.source rsp_chan
);

   localparam int DEPTH = 1 << VALUE_BITS;
   localparam logic [VALUE_BITS-1:0] VMAX = '1;

   // sequencing state
   rhi_state_type state_ff, state_in;
   logic          clearing;
   logic [VALUE_BITS-1:0] clr_addr_ff, clr_addr_in;

   // pipeline: stage b updates the value's entry, stage c updates h
   logic                  b_valid_ff, b_valid_in;
   logic                  c_valid_ff, c_valid_in;
   logic [VALUE_BITS-1:0] v_b_ff, v_c_ff;
   logic                  fwd_hit_ff;
   hist_type              fwd_data_ff;

   // running state
   logic [VALUE_BITS-1:0] h_ff, h_in;
   logic [VALUE_BITS:0]   cnt_ff, cnt_in;

   // result buffer
   logic [H_WIDTH-1:0] fifo_mem_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         fifo_count_ff, fifo_count_in;
   logic [1:0]         occupancy;
   logic               push, pop;

   // memory port signals
   logic                  ram_we;
   logic [VALUE_BITS-1:0] ram_waddr, ram_raddr;
   hist_type              ram_wdata, ram_rdata;

   logic                  accept;
   logic [31:0]           page_wide;
   logic [VALUE_BITS-1:0] v_req;
   logic [VALUE_BITS-1:0] h_plus;
   hist_type              inc_val;
   logic [VALUE_BITS:0]   cnt_up;
   logic                  grow;
   hist_type              f_val;
   logic [31:0]           cnt_wide, cnt_diff, h_wide;
   logic [H_WIDTH-1:0]    h_out;

   // next state of the sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == VMAX) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: state_in = ST_RUN;
         default: state_in = ST_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      clearing = 1'b0;
      unique case (state_ff)
         ST_CLEAR: clearing = 1'b1;
         ST_RUN:   clearing = 1'b0;
         default:  clearing = 1'b1;
      endcase
   end

   assign clr_addr_in = clr_addr_ff + {{(VALUE_BITS-1){1'b0}}, 1'b1};

   // clamp the incoming value to the histogram range
   assign page_wide = 32'(req_chan.page_count);
   assign v_req     = (page_wide > 32'(VMAX)) ? VMAX : page_wide[VALUE_BITS-1:0];

   // input handshake: read port not busy with an h+1 read and room for the result
   assign occupancy      = fifo_count_ff + {1'b0, c_valid_ff};
   assign req_chan.ready = !clearing && !b_valid_ff && (occupancy < 2'd2);
   assign accept         = req_chan.valid && req_chan.ready;

   assign b_valid_in = accept;
   assign c_valid_in = b_valid_ff;

   // histogram memory access
   assign h_plus    = h_ff + {{(VALUE_BITS-1){1'b0}}, 1'b1};
   assign inc_val   = (ram_rdata == '1) ? ram_rdata : ram_rdata + 32'd1;
   assign ram_we    = clearing || b_valid_ff;
   assign ram_waddr = clearing ? clr_addr_ff : v_b_ff;
   assign ram_wdata = clearing ? '0 : inc_val;
   assign ram_raddr = b_valid_ff ? h_plus : v_req;

   rhi_ram #(
      .WIDTH (HIST_WIDTH),
      .DEPTH (DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // h update: count values above h, step h when the count passes it
   always_comb begin
      cnt_up   = cnt_ff + {{VALUE_BITS{1'b0}}, (v_c_ff > h_ff)};
      grow     = (cnt_up > {1'b0, h_ff}) && (h_ff != VMAX);
      f_val    = fwd_hit_ff ? fwd_data_ff : ram_rdata;
      cnt_wide = 32'(cnt_up);
      cnt_diff = cnt_wide - f_val;
      h_in     = h_ff;
      cnt_in   = cnt_ff;
      if (c_valid_ff) begin
         cnt_in = cnt_up;
         if (grow) begin
            h_in = h_plus;
            if (f_val > cnt_wide) begin
               cnt_in = '0;
            end else begin
               cnt_in = cnt_diff[VALUE_BITS:0];
            end
         end
      end
      h_wide = 32'(h_in);
      h_out  = h_wide[H_WIDTH-1:0];
   end

   // result buffer control
   assign push          = c_valid_ff;
   assign pop           = rsp_chan.valid && rsp_chan.ready;
   assign fifo_count_in = fifo_count_ff + {1'b0, push} - {1'b0, pop};
   assign rsp_chan.valid   = (fifo_count_ff != 2'd0);
   assign rsp_chan.h_value = fifo_mem_ff[rd_ptr_ff];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         h_ff          <= '0;
         cnt_ff        <= '0;
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         fifo_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         b_valid_ff    <= b_valid_in;
         c_valid_ff    <= c_valid_in;
         h_ff          <= h_in;
         cnt_ff        <= cnt_in;
         fifo_count_ff <= fifo_count_in;
         if (clearing) begin
            clr_addr_ff <= clr_addr_in;
         end
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   // payload registers; forward the entry written while h+1 is read
   always_ff @(posedge clock) begin
      if (accept) begin
         v_b_ff <= v_req;
      end
      if (b_valid_ff) begin
         v_c_ff      <= v_b_ff;
         fwd_hit_ff  <= (h_plus == v_b_ff);
         fwd_data_ff <= inc_val;
      end
      if (push) begin
         fifo_mem_ff[wr_ptr_ff] <= h_out;
      end
   end

   // no input item is taken while the histogram is being cleared
   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_chan.ready)
      else $error("item accepted during histogram clear");

   // an item never sits in both pipeline stages at once
   assert property (@(posedge clock) disable iff (reset)
      !(b_valid_ff && c_valid_ff))
      else $error("pipeline stages overlap");

   // buffered and in-flight results never exceed the buffer
   assert property (@(posedge clock) disable iff (reset)
      (fifo_count_ff + {1'b0, b_valid_ff} + {1'b0, c_valid_ff}) <= 2'd2)
      else $error("result buffer overrun");

   // h only ever steps up by one
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (h_ff != $past(h_ff))) |->
         (h_ff == $past(h_ff) + {{(VALUE_BITS-1){1'b0}}, 1'b1}))
      else $error("h changed by more than one");

   // count of values above h never exceeds h
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= {1'b0, h_ff})
      else $error("count above h exceeds h");

endmodule
